### rtl/core/crt_pkg.sv
package crt_pkg;

  localparam int SLOT_COUNT   = 5;
  localparam int HEADER_BYTES = 32;
  localparam int IDX_W        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [FIFO_PTR_W-1:0] FIFO_LAST = FIFO_PTR_W'(FIFO_DEPTH - 1);
  localparam logic [FIFO_CNT_W-1:0] FIFO_FULL = FIFO_CNT_W'(FIFO_DEPTH);

  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] FK_NON_HT = 2'h1;
  localparam logic [1:0] FK_HT     = 2'h2;
  localparam int SC_NON_HT = 52;
  localparam int SC_HT     = 56;

  typedef enum logic [1:0] {
    OP_ARRIVAL = 2'd0,
    OP_EXPIRY  = 2'd1,
    OP_READ    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_INTERVAL   = 2'd0,
    CFG_FRAME_KIND = 2'd1,
    CFG_PRECISION  = 2'd2,
    CFG_ENABLE     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic        known;
    op_e         op;
    logic [31:0] time_now;
    logic        usable;
    logic [15:0] tag;
    logic [6:0]  subcarriers;
    logic [15:0] capacity;
  } cmd_t;

  typedef struct packed {
    logic        data_ready;
    logic [15:0] ready_length;
    logic        read_ok;
    logic [15:0] read_tag;
    logic [15:0] read_length;
    logic        timer_armed;
  } res_t;

  function automatic logic [15:0] nominal_len(logic [1:0] fk, logic prec);
    logic [15:0] len;
    len = 16'(HEADER_BYTES);
    if (fk == FK_NON_HT) begin
      len = len + (16'(SC_NON_HT) << (prec ? 2 : 1));
    end else if (fk == FK_HT) begin
      len = len + (16'(SC_HT) << (prec ? 2 : 1));
    end
    return len;
  endfunction

  function automatic logic [IDX_W-1:0] next_slot(logic [IDX_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + IDX_W'(1);
  endfunction

endpackage

### rtl/core/crt_front.sv
module crt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          operation_i,
  input  logic [31:0]         time_now_i,
  input  logic                capture_valid_i,
  input  logic [15:0]         capture_tag_i,
  input  logic [6:0]          subcarrier_count_i,
  input  logic [15:0]         read_capacity_i,
  output logic                cmd_valid_o,
  output crt_pkg::cmd_t       cmd_o,
  input  logic                cmd_take_i
);

  crt_pkg::cmd_t                    fifo_q [crt_pkg::FIFO_DEPTH];
  logic [crt_pkg::FIFO_PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [crt_pkg::FIFO_CNT_W-1:0]   count_q, count_d;
  crt_pkg::cmd_t                    cmd_in;
  logic                             do_push, do_pop;

  // classify the request
  always_comb begin
    cmd_in             = '0;
    cmd_in.time_now    = time_now_i;
    cmd_in.usable      = capture_valid_i && (subcarrier_count_i != 7'd0);
    cmd_in.tag         = capture_tag_i;
    cmd_in.subcarriers = subcarrier_count_i;
    cmd_in.capacity    = read_capacity_i;
    unique case (operation_i)
      crt_pkg::OP_ARRIVAL: begin
        cmd_in.known = 1'b1;
        cmd_in.op    = crt_pkg::OP_ARRIVAL;
      end
      crt_pkg::OP_EXPIRY: begin
        cmd_in.known = 1'b1;
        cmd_in.op    = crt_pkg::OP_EXPIRY;
      end
      crt_pkg::OP_READ: begin
        cmd_in.known = 1'b1;
        cmd_in.op    = crt_pkg::OP_READ;
      end
      default: begin
        cmd_in.known = 1'b0;
        cmd_in.op    = crt_pkg::OP_ARRIVAL;
      end
    endcase
  end

  assign full        = (count_q == crt_pkg::FIFO_FULL);
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_take_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == crt_pkg::FIFO_LAST) ? '0 : wr_ptr_q + crt_pkg::FIFO_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == crt_pkg::FIFO_LAST) ? '0 : rd_ptr_q + crt_pkg::FIFO_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + crt_pkg::FIFO_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - crt_pkg::FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

### rtl/core/crt_back.sv
module crt_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  input  crt_pkg::cmd_t                  cmd_i,
  output logic                           cmd_take_o,
  input  logic                           cfg_we_i,
  input  crt_pkg::cfg_idx_e              cfg_idx_i,
  input  logic [crt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                           res_valid_o,
  output crt_pkg::res_t                  res_o,
  input  logic                           res_take_i
);

  logic [15:0] interval_q, interval_d;
  logic [1:0]  fk_q, fk_d;
  logic        prec_q, prec_d;
  logic        en_q, en_d;

  logic [crt_pkg::SLOT_COUNT-1:0] recv_q, recv_d, rep_q, rep_d;
  logic [15:0] cap_q [crt_pkg::SLOT_COUNT];
  logic [15:0] cap_d [crt_pkg::SLOT_COUNT];
  logic [6:0]  sc_q  [crt_pkg::SLOT_COUNT];
  logic [6:0]  sc_d  [crt_pkg::SLOT_COUNT];
  logic [crt_pkg::IDX_W-1:0] ws_q, ws_d, rs_q, rs_d;
  logic [31:0] last_q, last_d;
  logic        timer_q, timer_d;

  logic          out_valid_q, out_valid_d;
  crt_pkg::res_t res_q, res_d;
  logic          take;

  assign take        = cmd_valid_i && (!out_valid_q || res_take_i);
  assign cmd_take_o  = take;
  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_comb begin
    logic                      usable, report, fk_ok;
    logic [crt_pkg::IDX_W-1:0] w, r;
    logic [15:0]               nom, nm1;
    logic [6:0]                n;

    interval_d = interval_q;
    fk_d       = fk_q;
    prec_d     = prec_q;
    en_d       = en_q;
    recv_d     = recv_q;
    rep_d      = rep_q;
    cap_d      = cap_q;
    sc_d       = sc_q;
    ws_d       = ws_q;
    rs_d       = rs_q;
    last_d     = last_q;
    timer_d    = timer_q;
    res_d      = res_q;

    w      = ws_q;
    r      = rs_q;
    fk_ok  = (fk_q == crt_pkg::FK_NON_HT) || (fk_q == crt_pkg::FK_HT);
    usable = cmd_i.usable && fk_ok;
    nom    = crt_pkg::nominal_len(fk_q, prec_q);
    n      = sc_q[r];
    nm1    = 16'(n) - 16'd1;
    report = 1'b0;

    out_valid_d = out_valid_q && !res_take_i;

    if (take) begin
      res_d       = '0;
      out_valid_d = 1'b1;
      if (cmd_i.known) begin
        unique case (cmd_i.op)
          crt_pkg::OP_ARRIVAL: begin
            if (en_q) begin
              if (last_q == 32'd0) begin
                last_d = cmd_i.time_now;
                report = 1'b1;
              end else if (cmd_i.time_now > last_q) begin
                if ((cmd_i.time_now - last_q) >= 32'(interval_q)) begin
                  last_d = cmd_i.time_now;
                  report = 1'b1;
                end else begin
                  if (usable) begin
                    cap_d[w] = cmd_i.tag;
                    sc_d[w]  = cmd_i.subcarriers;
                  end
                  recv_d[w] = 1'b1;
                end
              end else begin
                last_d = cmd_i.time_now;
              end
              if (report && !rep_q[w] && usable) begin
                cap_d[w]           = cmd_i.tag;
                sc_d[w]            = cmd_i.subcarriers;
                recv_d[w]          = 1'b1;
                rep_d[w]           = 1'b1;
                res_d.data_ready   = 1'b1;
                res_d.ready_length = nom;
                ws_d               = crt_pkg::next_slot(w);
                timer_d            = 1'b1;
              end
            end
          end
          crt_pkg::OP_EXPIRY: begin
            if (recv_q[w] && !rep_q[w]) begin
              res_d.data_ready   = 1'b1;
              res_d.ready_length = nom;
              rep_d[w]           = 1'b1;
              ws_d               = crt_pkg::next_slot(w);
              last_d             = cmd_i.time_now;
            end else begin
              timer_d = 1'b0;
            end
          end
          crt_pkg::OP_READ: begin
            if (rep_q[r]) begin
              res_d.read_ok  = 1'b1;
              res_d.read_tag = cap_q[r];
              if ((cmd_i.capacity >= nom) && fk_ok) begin
                res_d.read_length = 16'(crt_pkg::HEADER_BYTES) +
                  ((n == 7'd0) ? 16'd0 : (prec_q ? (nm1 << 2) : (nm1 << 1)));
              end
              rep_d[r]  = 1'b0;
              recv_d[r] = 1'b0;
              rs_d      = crt_pkg::next_slot(r);
            end
          end
          default: begin
          end
        endcase
      end
      res_d.timer_armed = timer_d;
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        crt_pkg::CFG_INTERVAL:   interval_d = cfg_data_i[15:0];
        crt_pkg::CFG_FRAME_KIND: fk_d       = cfg_data_i[1:0];
        crt_pkg::CFG_PRECISION:  prec_d     = cfg_data_i[0];
        crt_pkg::CFG_ENABLE: begin
          en_d    = cfg_data_i[0];
          recv_d  = '0;
          rep_d   = '0;
          for (int i = 0; i < crt_pkg::SLOT_COUNT; i++) begin
            cap_d[i] = '0;
            sc_d[i]  = '0;
          end
          ws_d    = '0;
          rs_d    = '0;
          timer_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q  <= '0;
      fk_q        <= '0;
      prec_q      <= 1'b0;
      en_q        <= 1'b0;
      recv_q      <= '0;
      rep_q       <= '0;
      for (int i = 0; i < crt_pkg::SLOT_COUNT; i++) begin
        cap_q[i] <= '0;
        sc_q[i]  <= '0;
      end
      ws_q        <= '0;
      rs_q        <= '0;
      last_q      <= '0;
      timer_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      interval_q  <= interval_d;
      fk_q        <= fk_d;
      prec_q      <= prec_d;
      en_q        <= en_d;
      recv_q      <= recv_d;
      rep_q       <= rep_d;
      cap_q       <= cap_d;
      sc_q        <= sc_d;
      ws_q        <= ws_d;
      rs_q        <= rs_d;
      last_q      <= last_d;
      timer_q     <= timer_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

### rtl/core/csi_report_throttle_ring_core.sv
// Report throttle for channel-state captures over a ring of report slots. Requests enter
// through a two-entry command queue that decodes the operation; the back end applies one
// request per cycle, unless a result waits unpopped, to the slot flags, ring indices,
// last report time and report timer, and holds its answer in a result register until
// popped. A request is registered in a queue entry, then in the result register; the
// queue keeps accepting while a result waits, until it is full. Configuration writes
// take effect at once and are meant for when no request is in flight; writing
// capture_enable clears every slot, both indices and the timer.
module csi_report_throttle_ring_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     operation_i,
  input  logic [31:0]                    time_now_i,
  input  logic                           capture_valid_i,
  input  logic [15:0]                    capture_tag_i,
  input  logic [6:0]                     subcarrier_count_i,
  input  logic [15:0]                    read_capacity_i,
  output logic                           empty,
  input  logic                           pop,
  output logic                           data_ready_o,
  output logic [15:0]                    ready_length_o,
  output logic                           read_ok_o,
  output logic [15:0]                    read_tag_o,
  output logic [15:0]                    read_length_o,
  output logic                           timer_armed_o,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [crt_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic          cmd_valid, cmd_take, res_valid;
  crt_pkg::cmd_t cmd;
  crt_pkg::res_t res;

  crt_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .operation_i        (operation_i),
    .time_now_i         (time_now_i),
    .capture_valid_i    (capture_valid_i),
    .capture_tag_i      (capture_tag_i),
    .subcarrier_count_i (subcarrier_count_i),
    .read_capacity_i    (read_capacity_i),
    .cmd_valid_o        (cmd_valid),
    .cmd_o              (cmd),
    .cmd_take_i         (cmd_take)
  );

  crt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (crt_pkg::cfg_idx_e'(cfg_idx_i)),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (pop)
  );

  assign empty          = !res_valid;
  assign data_ready_o   = res.data_ready;
  assign ready_length_o = res.ready_length;
  assign read_ok_o      = res.read_ok;
  assign read_tag_o     = res.read_tag;
  assign read_length_o  = res.read_length;
  assign timer_armed_o  = res.timer_armed;

endmodule

### rtl/core/crt_checker.sv
module crt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic        data_ready_o,
  input logic [15:0] ready_length_o,
  input logic        read_ok_o,
  input logic [15:0] read_tag_o,
  input logic [15:0] read_length_o,
  input logic        timer_armed_o
);

  // no result waits in the cycle after a reset cycle
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result shown during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(data_ready_o) && $stable(ready_length_o) &&
      $stable(read_ok_o) && $stable(read_tag_o) && $stable(read_length_o) &&
      $stable(timer_armed_o)))
    else $error("waiting result changed");

  // a failed read carries no tag or length
  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !read_ok_o) |-> (read_tag_o == 16'd0 && read_length_o == 16'd0))
    else $error("read fields set without read_ok");

  // a report and a read never come from one request, and ready_length is zero without a report
  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(data_ready_o && read_ok_o) &&
      (data_ready_o || (ready_length_o == 16'd0)))
    else $error("report and read fields mixed");

endmodule

bind csi_report_throttle_ring_core crt_checker u_crt_checker (.*);
